/* rtl/cna_pkg.sv */
// ----------------------------------------------------------------------------
// cna_pkg
// Shared types and constants of the complex arithmetic unit: transaction
// structs, operation codes and derived widths for signed Q16.16 operands.
// ----------------------------------------------------------------------------
`default_nettype none

package cna_pkg;

  localparam int DATA_W = 32;
  localparam int FRAC_W = 16;

  // full product and sum-of-products widths
  localparam int PROD_W = 2 * DATA_W;
  localparam int DEN_W  = 2 * DATA_W + 1;
  // dividend after the fraction shift, also the quotient width
  localparam int DIVD_W = DEN_W + FRAC_W;
  localparam int CNT_W  = $clog2(DIVD_W);

  localparam int FIFO_DEPTH = 4;
  localparam int PTR_W      = $clog2(FIFO_DEPTH);

  typedef logic signed [DATA_W-1:0] data_t;

  typedef enum logic [2:0] {
    OP_ADD  = 3'd0,
    OP_SUB  = 3'd1,
    OP_MUL  = 3'd2,
    OP_DIV  = 3'd3,
    OP_MOD  = 3'd4,
    OP_CONJ = 3'd5,
    OP_NONE = 3'd6
  } op_t;

  typedef struct packed {
    logic [2:0] func;
    data_t      a_real;
    data_t      a_imag;
    data_t      b_real;
    data_t      b_imag;
  } in_t;

  typedef struct packed {
    data_t res_real;
    data_t res_imag;
    logic  saturated;
    logic  div_by_zero;
  } out_t;

  // classified command between front and back
  typedef struct packed {
    op_t              op;
    logic             dz;
    data_t            ar;
    data_t            ai;
    data_t            br;
    data_t            bi;
    logic [PROD_W-1:0] br2;
    logic [PROD_W-1:0] bi2;
  } cmd_t;

endpackage

`default_nettype wire

/* rtl/cna_front.sv */
// ----------------------------------------------------------------------------
// cna_front
// Accepts transactions, decodes the operation, flags division by zero and
// squares the b operand (or a, for modulus) into a registered command.
// ----------------------------------------------------------------------------
`default_nettype none

module cna_front import cna_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_stall,
  input  in_t  in_data,
  output logic q_valid,
  input  logic q_stall,
  output cmd_t q_cmd
);

  logic  f_valid;
  cmd_t  f_cmd;
  cmd_t  cmd_next;
  op_t   op;
  data_t sq_re;
  data_t sq_im;
  logic  push;
  logic  load;

  assign push     = f_valid && !q_stall;
  assign load     = !f_valid || push;
  assign in_stall = !load;
  assign q_valid  = f_valid;
  assign q_cmd    = f_cmd;

  // operation decode, unused codes fall to no-op
  always_comb begin
    unique case (in_data.func)
      OP_ADD:  op = OP_ADD;
      OP_SUB:  op = OP_SUB;
      OP_MUL:  op = OP_MUL;
      OP_DIV:  op = OP_DIV;
      OP_MOD:  op = OP_MOD;
      OP_CONJ: op = OP_CONJ;
      default: op = OP_NONE;
    endcase
  end

  // modulus squares a, everything else squares b
  assign sq_re = (op == OP_MOD) ? in_data.a_real : in_data.b_real;
  assign sq_im = (op == OP_MOD) ? in_data.a_imag : in_data.b_imag;

  always_comb begin
    cmd_next     = '0;
    cmd_next.op  = op;
    cmd_next.dz  = (op == OP_DIV) && (in_data.b_real == '0) && (in_data.b_imag == '0);
    cmd_next.ar  = in_data.a_real;
    cmd_next.ai  = in_data.a_imag;
    cmd_next.br  = in_data.b_real;
    cmd_next.bi  = in_data.b_imag;
    cmd_next.br2 = PROD_W'(PROD_W'(sq_re) * PROD_W'(sq_re));
    cmd_next.bi2 = PROD_W'(PROD_W'(sq_im) * PROD_W'(sq_im));
  end

  // command register
  always_ff @(posedge clk) begin
    if (rst) begin
      f_valid <= 1'b0;
    end else if (load) begin
      f_valid <= in_valid;
    end
    if (load) begin
      f_cmd <= cmd_next;
    end
  end

endmodule

`default_nettype wire

/* rtl/cna_fifo.sv */
// ----------------------------------------------------------------------------
// cna_fifo
// Short command queue between front and back so each side stalls on its own.
// ----------------------------------------------------------------------------
`default_nettype none

module cna_fifo import cna_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic wr_valid,
  output logic wr_stall,
  input  cmd_t wr_data,
  output logic rd_valid,
  input  logic rd_stall,
  output cmd_t rd_data
);

  cmd_t             mem [FIFO_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [PTR_W:0]   count;
  logic             wr_en;
  logic             rd_en;

  assign wr_stall = (count == (PTR_W+1)'(FIFO_DEPTH));
  assign rd_valid = (count != '0);
  assign wr_en    = wr_valid && !wr_stall;
  assign rd_en    = rd_valid && !rd_stall;
  assign rd_data  = mem[rd_ptr];

  // storage
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_ptr] <= wr_data;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (rd_en) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (wr_en && !rd_en) begin
        count <= count + 1'b1;
      end else if (rd_en && !wr_en) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

/* rtl/cna_back.sv */
// ----------------------------------------------------------------------------
// cna_back
// Executes commands: cross products in one stage, then direct add/sub/mul/
// conj/divide-by-zero with saturation, or a bit-serial divide / square root.
// ----------------------------------------------------------------------------
`default_nettype none

module cna_back import cna_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic q_valid,
  output logic q_stall,
  input  cmd_t q_cmd,
  output logic out_valid,
  input  logic out_stall,
  output out_t out_data
);

  localparam logic [DIVD_W-1:0] HALF = DIVD_W'(1) << (DATA_W - 1);

  // absolute value of a wide signed value
  function automatic logic [DIVD_W-1:0] mag_of(input logic signed [DIVD_W-1:0] x);
    logic [DIVD_W-1:0] m;
    m = x[DIVD_W-1] ? DIVD_W'(-x) : DIVD_W'(x);
    return m;
  endfunction

  // clip a sign and magnitude to the data range, flag in the top bit
  function automatic logic [DATA_W:0] sat_pack(input logic neg,
                                               input logic [DIVD_W-1:0] mag);
    logic [DIVD_W-1:0] lim;
    logic [DIVD_W-1:0] m;
    logic              sat;
    lim = neg ? HALF : HALF - 1'b1;
    sat = (mag > lim);
    m   = sat ? lim : mag;
    return {sat, neg ? DATA_W'(-m[DATA_W-1:0]) : m[DATA_W-1:0]};
  endfunction

  // execute stage
  logic                     s1_valid;
  cmd_t                     s1_cmd;
  logic signed [PROD_W-1:0] s1_prr;
  logic signed [PROD_W-1:0] s1_pii;
  logic signed [PROD_W-1:0] s1_pir;
  logic signed [PROD_W-1:0] s1_pri;

  // serial unit
  logic              it_run;
  logic              it_done;
  logic [CNT_W-1:0]  it_cnt;
  logic [DIVD_W-1:0] dvd_re;
  logic [DIVD_W-1:0] dvd_im;
  logic [DEN_W-1:0]  rem_re;
  logic [DEN_W-1:0]  rem_im;
  logic [DIVD_W-1:0] q_re;
  logic [DIVD_W-1:0] q_im;
  logic [DEN_W-1:0]  den;
  logic              neg_re;
  logic              neg_im;
  logic [PROD_W-1:0] sq_src;
  logic [DATA_W+1:0] sq_rem;
  logic [DATA_W-1:0] sq_root;

  logic                     iterative;
  logic                     out_free;
  logic                     finish_simple;
  logic                     finish_iter;
  logic                     s1_free;
  logic                     start;
  logic signed [DIVD_W-1:0] num_re;
  logic signed [DIVD_W-1:0] num_im;
  logic [DEN_W-1:0]         den_sum;
  logic [DEN_W:0]           rsh_re;
  logic [DEN_W:0]           rsh_im;
  logic                     ge_re;
  logic                     ge_im;
  logic [DATA_W+1:0]        sq_r4;
  logic [DATA_W+1:0]        sq_trial;
  logic                     sq_ge;
  out_t                     res;

  assign iterative     = ((s1_cmd.op == OP_DIV) && !s1_cmd.dz) || (s1_cmd.op == OP_MOD);
  assign out_free      = !out_valid || !out_stall;
  assign finish_simple = s1_valid && !iterative && out_free;
  assign finish_iter   = s1_valid && iterative && it_done && out_free;
  assign s1_free       = !s1_valid || finish_simple || finish_iter;
  assign q_stall       = !s1_free;
  assign start         = s1_valid && iterative && !it_run && !it_done;

  // cross products on the way into the execute stage
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s1_free) begin
      s1_valid <= q_valid;
    end
    if (s1_free && q_valid) begin
      s1_cmd <= q_cmd;
      s1_prr <= PROD_W'(q_cmd.ar) * PROD_W'(q_cmd.br);
      s1_pii <= PROD_W'(q_cmd.ai) * PROD_W'(q_cmd.bi);
      s1_pir <= PROD_W'(q_cmd.ai) * PROD_W'(q_cmd.br);
      s1_pri <= PROD_W'(q_cmd.ar) * PROD_W'(q_cmd.bi);
    end
  end

  // divide numerators and denominator (sum of squares also feeds the root)
  assign num_re  = DIVD_W'(s1_prr) + DIVD_W'(s1_pii);
  assign num_im  = DIVD_W'(s1_pir) - DIVD_W'(s1_pri);
  assign den_sum = DEN_W'(s1_cmd.br2) + DEN_W'(s1_cmd.bi2);

  // one restoring divide step per lane
  assign rsh_re = {rem_re, dvd_re[DIVD_W-1]};
  assign rsh_im = {rem_im, dvd_im[DIVD_W-1]};
  assign ge_re  = (rsh_re >= {1'b0, den});
  assign ge_im  = (rsh_im >= {1'b0, den});

  // one square root digit
  assign sq_r4    = {sq_rem[DATA_W-1:0], sq_src[PROD_W-1 -: 2]};
  assign sq_trial = {sq_root, 2'b01};
  assign sq_ge    = (sq_r4 >= sq_trial);

  // serial divide / square root sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      it_run  <= 1'b0;
      it_done <= 1'b0;
    end else if (start) begin
      it_run <= 1'b1;
    end else if (it_run && (it_cnt == '0)) begin
      it_run  <= 1'b0;
      it_done <= 1'b1;
    end else if (finish_iter) begin
      it_done <= 1'b0;
    end
    if (start) begin
      it_cnt  <= (s1_cmd.op == OP_MOD) ? CNT_W'(DATA_W - 1) : CNT_W'(DIVD_W - 1);
      dvd_re  <= mag_of(num_re) << FRAC_W;
      dvd_im  <= mag_of(num_im) << FRAC_W;
      neg_re  <= num_re[DIVD_W-1];
      neg_im  <= num_im[DIVD_W-1];
      rem_re  <= '0;
      rem_im  <= '0;
      q_re    <= '0;
      q_im    <= '0;
      den     <= den_sum;
      sq_src  <= den_sum[PROD_W-1:0];
      sq_rem  <= '0;
      sq_root <= '0;
    end else if (it_run) begin
      it_cnt  <= it_cnt - 1'b1;
      dvd_re  <= dvd_re << 1;
      dvd_im  <= dvd_im << 1;
      rem_re  <= ge_re ? DEN_W'(rsh_re - {1'b0, den}) : rsh_re[DEN_W-1:0];
      rem_im  <= ge_im ? DEN_W'(rsh_im - {1'b0, den}) : rsh_im[DEN_W-1:0];
      q_re    <= {q_re[DIVD_W-2:0], ge_re};
      q_im    <= {q_im[DIVD_W-2:0], ge_im};
      sq_src  <= sq_src << 2;
      sq_rem  <= sq_ge ? sq_r4 - sq_trial : sq_r4;
      sq_root <= {sq_root[DATA_W-2:0], sq_ge};
    end
  end

  // result select and saturation
  always_comb begin
    logic                     nr;
    logic                     ni;
    logic [DIVD_W-1:0]        mr;
    logic [DIVD_W-1:0]        mi;
    logic signed [DIVD_W-1:0] vr;
    logic signed [DIVD_W-1:0] vi;
    logic [DATA_W:0]          pr;
    logic [DATA_W:0]          pi;
    vr = '0;
    vi = '0;
    nr = 1'b0;
    ni = 1'b0;
    mr = '0;
    mi = '0;
    unique case (s1_cmd.op)
      OP_ADD: begin
        vr = DIVD_W'(s1_cmd.ar) + DIVD_W'(s1_cmd.br);
        vi = DIVD_W'(s1_cmd.ai) + DIVD_W'(s1_cmd.bi);
        nr = vr[DIVD_W-1];
        ni = vi[DIVD_W-1];
        mr = mag_of(vr);
        mi = mag_of(vi);
      end
      OP_SUB: begin
        vr = DIVD_W'(s1_cmd.ar) - DIVD_W'(s1_cmd.br);
        vi = DIVD_W'(s1_cmd.ai) - DIVD_W'(s1_cmd.bi);
        nr = vr[DIVD_W-1];
        ni = vi[DIVD_W-1];
        mr = mag_of(vr);
        mi = mag_of(vi);
      end
      OP_MUL: begin
        vr = DIVD_W'(s1_prr) - DIVD_W'(s1_pii);
        vi = DIVD_W'(s1_pir) + DIVD_W'(s1_pri);
        nr = vr[DIVD_W-1];
        ni = vi[DIVD_W-1];
        mr = mag_of(vr) >> FRAC_W;
        mi = mag_of(vi) >> FRAC_W;
      end
      OP_DIV: begin
        nr = neg_re && !s1_cmd.dz;
        ni = neg_im && !s1_cmd.dz;
        mr = s1_cmd.dz ? '0 : q_re;
        mi = s1_cmd.dz ? '0 : q_im;
      end
      OP_MOD: begin
        mr = DIVD_W'(sq_root);
      end
      OP_CONJ: begin
        vr = DIVD_W'(s1_cmd.ar);
        vi = -DIVD_W'(s1_cmd.ai);
        nr = vr[DIVD_W-1];
        ni = vi[DIVD_W-1];
        mr = mag_of(vr);
        mi = mag_of(vi);
      end
      default: begin
        mr = '0;
      end
    endcase
    pr = sat_pack(nr, mr);
    pi = sat_pack(ni, mi);
    res.res_real    = pr[DATA_W-1:0];
    res.res_imag    = pi[DATA_W-1:0];
    res.saturated   = pr[DATA_W] | pi[DATA_W];
    res.div_by_zero = (s1_cmd.op == OP_DIV) && s1_cmd.dz;
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= finish_simple || finish_iter;
    end
    if (finish_simple || finish_iter) begin
      out_data <= res;
    end
  end

  a_run_has_cmd : assert property (@(posedge clk) disable iff (rst)
    it_run |-> (s1_valid && iterative))
    else $error("serial unit running without an iterative command");

  a_run_done_excl : assert property (@(posedge clk) disable iff (rst)
    !(it_run && it_done))
    else $error("serial unit running and done at once");

  a_one_finish : assert property (@(posedge clk) disable iff (rst)
    $onehot0({finish_simple, finish_iter}))
    else $error("two completions in one cycle");

  a_dz_zero : assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_data.div_by_zero) |->
      (out_data.res_real == '0 && out_data.res_imag == '0 && !out_data.saturated))
    else $error("divide by zero with nonzero result");

  a_done_holds : assert property (@(posedge clk) disable iff (rst)
    (it_done && !finish_iter) |=> it_done)
    else $error("finished divide result lost");

endmodule

`default_nettype wire

/* rtl/complex_number_alu_core.sv */
// ----------------------------------------------------------------------------
// complex_number_alu_core
// Complex add, subtract, multiply, divide, modulus and conjugate on signed
// Q16.16 operands with saturation and a divide-by-zero flag.
// ----------------------------------------------------------------------------
// Throughput: one transaction per cycle for add, sub, mul, conj and divide
//   by zero while the output is not stalled; divide and modulus hold the
//   back end for the bit-serial divide / root unit (81 steps per divide,
//   32 per root) until the result is taken, while the queue takes more.
// Reset: synchronous; clears all valid flags and queue pointers.
`default_nettype none

module complex_number_alu_core import cna_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_stall,
  input  in_t  in_data,
  output logic out_valid,
  input  logic out_stall,
  output out_t out_data
);

  logic fq_valid;
  logic fq_stall;
  cmd_t fq_cmd;
  logic qb_valid;
  logic qb_stall;
  cmd_t qb_cmd;

  cna_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .q_valid  (fq_valid),
    .q_stall  (fq_stall),
    .q_cmd    (fq_cmd)
  );

  cna_fifo u_fifo (
    .clk      (clk),
    .rst      (rst),
    .wr_valid (fq_valid),
    .wr_stall (fq_stall),
    .wr_data  (fq_cmd),
    .rd_valid (qb_valid),
    .rd_stall (qb_stall),
    .rd_data  (qb_cmd)
  );

  cna_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (qb_valid),
    .q_stall   (qb_stall),
    .q_cmd     (qb_cmd),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire
